// ===== rtl/ldpm_pkg.sv =====
`timescale 1ns / 1ps
package ldpm_pkg;

   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;

   localparam logic [2:0] REG_FOCAL_X    = 3'd0;
   localparam logic [2:0] REG_FOCAL_Y    = 3'd1;
   localparam logic [2:0] REG_PRIN_X     = 3'd2;
   localparam logic [2:0] REG_PRIN_Y     = 3'd3;
   localparam logic [2:0] REG_RADIAL_K1  = 3'd4;
   localparam logic [2:0] REG_RADIAL_K2  = 3'd5;
   localparam logic [2:0] REG_RADIAL_K3  = 3'd6;
   localparam logic [2:0] REG_TANGENTIAL = 3'd7;

   localparam logic [30:0] FOCAL_RESET = 31'd65536;
   localparam logic signed [31:0] Q24_ONE = 32'sd16777216;

   localparam logic signed [65:0] SAT_HI = 66'sd2147483647;
   localparam logic signed [65:0] SAT_LO = -66'sd2147483648;

   // divider: 33 quotient bits, four per stage
   localparam int QBITS = 33;
   localparam int DIV_STEPS = 4;
   localparam int DIV_STAGES = (QBITS + DIV_STEPS - 1) / DIV_STEPS;
   localparam int DIV_LAT = DIV_STAGES + 2;
   localparam int CORE_LAT = 13;
   localparam int LATENCY = DIV_LAT + CORE_LAT;

   typedef struct packed {
      logic [30:0]        focal_x;
      logic [30:0]        focal_y;
      logic [30:0]        prin_x;
      logic [30:0]        prin_y;
      logic signed [31:0] k1;
      logic signed [31:0] k2;
      logic signed [31:0] k3;
      logic signed [31:0] p1;
      logic signed [31:0] p2;
   } cfg_type;

   // {overflow, value}
   function automatic logic [32:0] sat_q(input logic signed [65:0] v);
      if (v > SAT_HI) begin
         return {1'b1, 32'h7fff_ffff};
      end else if (v < SAT_LO) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   function automatic logic signed [65:0] x32(input logic signed [31:0] a);
      return {{34{a[31]}}, a};
   endfunction

   // floor(p / 2^24)
   function automatic logic signed [65:0] fl24(input logic signed [63:0] p);
      return {{26{p[63]}}, p[63:24]};
   endfunction

endpackage

// ===== rtl/ldpm_csr.sv =====
`timescale 1ns / 1ps
module ldpm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ldpm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ldpm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ldpm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output ldpm_pkg::cfg_type               cfg
);
   import ldpm_pkg::*;

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] idx;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;
   assign idx    = paddr[5:3];
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x <= FOCAL_RESET;
         cfg_ff.focal_y <= FOCAL_RESET;
         cfg_ff.prin_x  <= '0;
         cfg_ff.prin_y  <= '0;
         cfg_ff.k1      <= '0;
         cfg_ff.k2      <= '0;
         cfg_ff.k3      <= '0;
         cfg_ff.p1      <= '0;
         cfg_ff.p2      <= '0;
      end else if (wr_en) begin
         case (idx)
            REG_FOCAL_X:    cfg_ff.focal_x <= pwdata[30:0];
            REG_FOCAL_Y:    cfg_ff.focal_y <= pwdata[30:0];
            REG_PRIN_X:     cfg_ff.prin_x  <= pwdata[30:0];
            REG_PRIN_Y:     cfg_ff.prin_y  <= pwdata[30:0];
            REG_RADIAL_K1:  cfg_ff.k1      <= pwdata[31:0];
            REG_RADIAL_K2:  cfg_ff.k2      <= pwdata[31:0];
            REG_RADIAL_K3:  cfg_ff.k3      <= pwdata[31:0];
            REG_TANGENTIAL: begin
               cfg_ff.p1 <= pwdata[31:0];
               cfg_ff.p2 <= pwdata[63:32];
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         REG_FOCAL_X:    prdata = {33'd0, cfg_ff.focal_x};
         REG_FOCAL_Y:    prdata = {33'd0, cfg_ff.focal_y};
         REG_PRIN_X:     prdata = {33'd0, cfg_ff.prin_x};
         REG_PRIN_Y:     prdata = {33'd0, cfg_ff.prin_y};
         REG_RADIAL_K1:  prdata = {32'd0, cfg_ff.k1};
         REG_RADIAL_K2:  prdata = {32'd0, cfg_ff.k2};
         REG_RADIAL_K3:  prdata = {32'd0, cfg_ff.k3};
         REG_TANGENTIAL: prdata = {cfg_ff.p2, cfg_ff.p1};
         default:        prdata = '0;
      endcase
   end

   a_focal_wr: assert property (@(posedge clock) disable iff (reset)
      wr_en && idx == REG_FOCAL_X |=> cfg_ff.focal_x == $past(pwdata[30:0]))
      else $error("focal_x write lost");

endmodule

// ===== rtl/ldpm_div.sv =====
`timescale 1ns / 1ps
module ldpm_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_vld,
   input  logic signed [31:0] point,
   input  logic [30:0]        center,
   input  logic [30:0]        focal,
   output logic               out_vld,
   output logic signed [31:0] quot,
   output logic               ovf
);
   import ldpm_pkg::*;

   logic [DIV_STAGES:0] vld_ff;
   logic [30:0]         rem_ff  [DIV_STAGES+1];
   logic [32:0]         low_ff  [DIV_STAGES+1];
   logic [32:0]         q_ff    [DIV_STAGES+1];
   logic [30:0]         f_ff    [DIV_STAGES+1];
   logic                neg_ff  [DIV_STAGES+1];
   logic                big_ff  [DIV_STAGES+1];

   logic signed [32:0]  diff_in;
   logic [31:0]         mag_in;
   logic [55:0]         sh_in;
   logic [30:0]         fz_in;
   logic                out_vld_ff;
   logic signed [31:0]  quot_ff;
   logic                ovf_ff;
   logic signed [65:0]  sv_in;
   logic [32:0]         res_in;

   assign diff_in = {point[31], point} - {2'b00, center};
   assign mag_in  = diff_in[32] ? 32'(-diff_in) : diff_in[31:0];
   assign sh_in   = {mag_in, 24'd0};
   assign fz_in   = (focal == '0) ? 31'd1 : focal;

   always_ff @(posedge clock) begin
      rem_ff[0] <= {8'd0, sh_in[55:33]};
      low_ff[0] <= sh_in[32:0];
      q_ff[0]   <= '0;
      f_ff[0]   <= fz_in;
      neg_ff[0] <= diff_in[32];
      big_ff[0] <= {8'd0, sh_in[55:33]} >= fz_in;
   end

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [30:0] rem_in;
      logic [32:0] low_in;
      logic [32:0] q_in;

      always_comb begin
         logic [31:0] sh;
         rem_in = rem_ff[k];
         low_in = low_ff[k];
         q_in   = q_ff[k];
         for (int j = 0; j < DIV_STEPS; j++) begin
            if (k * DIV_STEPS + j < QBITS) begin
               sh     = {rem_in, low_in[32]};
               low_in = {low_in[31:0], 1'b0};
               if (sh >= {1'b0, f_ff[k]}) begin
                  rem_in = 31'(sh - {1'b0, f_ff[k]});
                  q_in   = {q_in[31:0], 1'b1};
               end else begin
                  rem_in = sh[30:0];
                  q_in   = {q_in[31:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         rem_ff[k+1] <= rem_in;
         low_ff[k+1] <= low_in;
         q_ff[k+1]   <= q_in;
         f_ff[k+1]   <= f_ff[k];
         neg_ff[k+1] <= neg_ff[k];
         big_ff[k+1] <= big_ff[k];
      end
   end

   always_comb begin
      sv_in = neg_ff[DIV_STAGES] ? -$signed({33'd0, q_ff[DIV_STAGES]})
                                 : $signed({33'd0, q_ff[DIV_STAGES]});
      if (big_ff[DIV_STAGES]) begin
         res_in = neg_ff[DIV_STAGES] ? {1'b1, 32'h8000_0000} : {1'b1, 32'h7fff_ffff};
      end else begin
         res_in = sat_q(sv_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         vld_ff     <= {vld_ff[DIV_STAGES-1:0], in_vld};
         out_vld_ff <= vld_ff[DIV_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= res_in[31:0];
      ovf_ff  <= res_in[32];
   end

   assign out_vld = out_vld_ff;
   assign quot    = quot_ff;
   assign ovf     = ovf_ff;

endmodule

// ===== rtl/ldpm_core.sv =====
`timescale 1ns / 1ps
module ldpm_core (
   input  logic               clock,
   input  logic               reset,
   input  ldpm_pkg::cfg_type  cfg,
   input  logic               in_vld,
   input  logic signed [31:0] u,
   input  logic signed [31:0] v,
   input  logic               in_ovf,
   output logic               out_vld,
   output logic signed [31:0] wx,
   output logic signed [31:0] wy,
   output logic               out_ovf
);
   import ldpm_pkg::*;

   logic [CORE_LAT:1] vld_ff;

   logic signed [31:0] s1_u_ff, s1_v_ff;
   logic signed [63:0] s1_puu_ff, s1_pvv_ff, s1_puv_ff;
   logic               s1_ov_ff;

   logic signed [31:0] s2_u_ff, s2_v_ff, s2_x2_ff, s2_y2_ff, s2_xy2_ff;
   logic               s2_ov_ff;
   logic [32:0]        x2_s, y2_s, xy2_s;

   logic signed [31:0] s3_u_ff, s3_v_ff, s3_x2_ff, s3_y2_ff, s3_xy2_ff, s3_r2_ff;
   logic               s3_ov_ff;
   logic [32:0]        r2_s;

   logic signed [31:0] s4_u_ff, s4_v_ff, s4_xy2_ff, s4_r2_ff, s4_sx_ff, s4_sy_ff;
   logic signed [63:0] s4_pk3_ff;
   logic               s4_ov_ff;
   logic [32:0]        sx_s, sy_s;

   logic signed [31:0] s5_u_ff, s5_v_ff, s5_xy2_ff, s5_r2_ff, s5_sx_ff, s5_sy_ff, s5_t_ff;
   logic               s5_ov_ff;
   logic [32:0]        t1_s;

   logic signed [31:0] s6_u_ff, s6_v_ff, s6_xy2_ff, s6_r2_ff, s6_sx_ff, s6_sy_ff;
   logic signed [63:0] s6_pt_ff;
   logic               s6_ov_ff;

   logic signed [31:0] s7_u_ff, s7_v_ff, s7_xy2_ff, s7_r2_ff, s7_sx_ff, s7_sy_ff, s7_t_ff;
   logic               s7_ov_ff;
   logic [32:0]        t2_s;

   logic signed [31:0] s8_u_ff, s8_v_ff, s8_xy2_ff, s8_sx_ff, s8_sy_ff;
   logic signed [63:0] s8_pt_ff;
   logic               s8_ov_ff;

   logic signed [31:0] s9_u_ff, s9_v_ff, s9_xy2_ff, s9_sx_ff, s9_sy_ff, s9_kr_ff;
   logic               s9_ov_ff;
   logic [32:0]        t3_s, kr_s;

   logic signed [63:0] s10_pux_ff, s10_p1x_ff, s10_p2x_ff;
   logic signed [63:0] s10_pvy_ff, s10_p1y_ff, s10_p2y_ff;
   logic               s10_ov_ff;

   logic signed [31:0] s11_xd_ff, s11_yd_ff;
   logic               s11_ov_ff;
   logic [32:0]        xd_s, yd_s;

   logic signed [63:0] s12_pfx_ff, s12_pfy_ff;
   logic               s12_ov_ff;

   logic signed [31:0] s13_wx_ff, s13_wy_ff;
   logic               s13_ov_ff;
   logic [32:0]        wx_s, wy_s;

   logic signed [63:0] puu_in, pvv_in, puv_in, pk3_in, pt1_in, pt2_in;
   logic signed [63:0] pux_in, p1x_in, p2x_in, pvy_in, p1y_in, p2y_in;
   logic signed [63:0] pfx_in, pfy_in;

   assign puu_in = u * u;
   assign pvv_in = v * v;
   assign puv_in = u * v;

   assign x2_s  = sat_q(fl24(s1_puu_ff));
   assign y2_s  = sat_q(fl24(s1_pvv_ff));
   assign xy2_s = sat_q(fl24(s1_puv_ff) + fl24(s1_puv_ff));

   assign r2_s = sat_q(x32(s2_x2_ff) + x32(s2_y2_ff));

   assign sx_s   = sat_q(x32(s3_r2_ff) + x32(s3_x2_ff) + x32(s3_x2_ff));
   assign sy_s   = sat_q(x32(s3_r2_ff) + x32(s3_y2_ff) + x32(s3_y2_ff));
   assign pk3_in = cfg.k3 * s3_r2_ff;

   assign t1_s   = sat_q(fl24(s4_pk3_ff) + x32(cfg.k2));
   assign pt1_in = s5_t_ff * s5_r2_ff;
   assign t2_s   = sat_q(fl24(s6_pt_ff) + x32(cfg.k1));
   assign pt2_in = s7_t_ff * s7_r2_ff;
   assign t3_s   = sat_q(fl24(s8_pt_ff));
   assign kr_s   = sat_q(x32(Q24_ONE) + x32(t3_s[31:0]));

   assign pux_in = s9_u_ff * s9_kr_ff;
   assign p1x_in = cfg.p1 * s9_xy2_ff;
   assign p2x_in = cfg.p2 * s9_sx_ff;
   assign pvy_in = s9_v_ff * s9_kr_ff;
   assign p1y_in = cfg.p1 * s9_sy_ff;
   assign p2y_in = cfg.p2 * s9_xy2_ff;

   assign xd_s = sat_q(fl24(s10_pux_ff) + fl24(s10_p1x_ff) + fl24(s10_p2x_ff));
   assign yd_s = sat_q(fl24(s10_pvy_ff) + fl24(s10_p1y_ff) + fl24(s10_p2y_ff));

   assign pfx_in = $signed({1'b0, cfg.focal_x}) * s11_xd_ff;
   assign pfy_in = $signed({1'b0, cfg.focal_y}) * s11_yd_ff;

   assign wx_s = sat_q(fl24(s12_pfx_ff) + $signed({35'd0, cfg.prin_x}));
   assign wy_s = sat_q(fl24(s12_pfy_ff) + $signed({35'd0, cfg.prin_y}));

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[CORE_LAT-1:1], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      s1_u_ff   <= u;
      s1_v_ff   <= v;
      s1_puu_ff <= puu_in;
      s1_pvv_ff <= pvv_in;
      s1_puv_ff <= puv_in;
      s1_ov_ff  <= in_ovf;

      s2_u_ff   <= s1_u_ff;
      s2_v_ff   <= s1_v_ff;
      s2_x2_ff  <= x2_s[31:0];
      s2_y2_ff  <= y2_s[31:0];
      s2_xy2_ff <= xy2_s[31:0];
      s2_ov_ff  <= s1_ov_ff | x2_s[32] | y2_s[32] | xy2_s[32];

      s3_u_ff   <= s2_u_ff;
      s3_v_ff   <= s2_v_ff;
      s3_x2_ff  <= s2_x2_ff;
      s3_y2_ff  <= s2_y2_ff;
      s3_xy2_ff <= s2_xy2_ff;
      s3_r2_ff  <= r2_s[31:0];
      s3_ov_ff  <= s2_ov_ff | r2_s[32];

      s4_u_ff   <= s3_u_ff;
      s4_v_ff   <= s3_v_ff;
      s4_xy2_ff <= s3_xy2_ff;
      s4_r2_ff  <= s3_r2_ff;
      s4_sx_ff  <= sx_s[31:0];
      s4_sy_ff  <= sy_s[31:0];
      s4_pk3_ff <= pk3_in;
      s4_ov_ff  <= s3_ov_ff | sx_s[32] | sy_s[32];

      s5_u_ff   <= s4_u_ff;
      s5_v_ff   <= s4_v_ff;
      s5_xy2_ff <= s4_xy2_ff;
      s5_r2_ff  <= s4_r2_ff;
      s5_sx_ff  <= s4_sx_ff;
      s5_sy_ff  <= s4_sy_ff;
      s5_t_ff   <= t1_s[31:0];
      s5_ov_ff  <= s4_ov_ff | t1_s[32];

      s6_u_ff   <= s5_u_ff;
      s6_v_ff   <= s5_v_ff;
      s6_xy2_ff <= s5_xy2_ff;
      s6_r2_ff  <= s5_r2_ff;
      s6_sx_ff  <= s5_sx_ff;
      s6_sy_ff  <= s5_sy_ff;
      s6_pt_ff  <= pt1_in;
      s6_ov_ff  <= s5_ov_ff;

      s7_u_ff   <= s6_u_ff;
      s7_v_ff   <= s6_v_ff;
      s7_xy2_ff <= s6_xy2_ff;
      s7_r2_ff  <= s6_r2_ff;
      s7_sx_ff  <= s6_sx_ff;
      s7_sy_ff  <= s6_sy_ff;
      s7_t_ff   <= t2_s[31:0];
      s7_ov_ff  <= s6_ov_ff | t2_s[32];

      s8_u_ff   <= s7_u_ff;
      s8_v_ff   <= s7_v_ff;
      s8_xy2_ff <= s7_xy2_ff;
      s8_sx_ff  <= s7_sx_ff;
      s8_sy_ff  <= s7_sy_ff;
      s8_pt_ff  <= pt2_in;
      s8_ov_ff  <= s7_ov_ff;

      s9_u_ff   <= s8_u_ff;
      s9_v_ff   <= s8_v_ff;
      s9_xy2_ff <= s8_xy2_ff;
      s9_sx_ff  <= s8_sx_ff;
      s9_sy_ff  <= s8_sy_ff;
      s9_kr_ff  <= kr_s[31:0];
      s9_ov_ff  <= s8_ov_ff | t3_s[32] | kr_s[32];

      s10_pux_ff <= pux_in;
      s10_p1x_ff <= p1x_in;
      s10_p2x_ff <= p2x_in;
      s10_pvy_ff <= pvy_in;
      s10_p1y_ff <= p1y_in;
      s10_p2y_ff <= p2y_in;
      s10_ov_ff  <= s9_ov_ff;

      s11_xd_ff <= xd_s[31:0];
      s11_yd_ff <= yd_s[31:0];
      s11_ov_ff <= s10_ov_ff | xd_s[32] | yd_s[32];

      s12_pfx_ff <= pfx_in;
      s12_pfy_ff <= pfy_in;
      s12_ov_ff  <= s11_ov_ff;

      s13_wx_ff <= wx_s[31:0];
      s13_wy_ff <= wy_s[31:0];
      s13_ov_ff <= s12_ov_ff | wx_s[32] | wy_s[32];
   end

   assign out_vld = vld_ff[CORE_LAT];
   assign wx      = s13_wx_ff;
   assign wy      = s13_wy_ff;
   assign out_ovf = s13_ov_ff;

endmodule

// ===== rtl/lens_distortion_point_mapper.sv =====
`timescale 1ns / 1ps
// Brown-Conrady lens distortion, forward direction, fixed point.
// Input: pulse start with req_point_x/req_point_y (Q16.16); busy is always
// low, so a transaction can be issued every cycle.
// Output: rsp_valid is high for one cycle with rsp_warped_x/rsp_warped_y
// (Q16.16, saturated) and rsp_overflow; results come back in issue order.
// Each point passes through the normalizing divider and then the
// polynomial pipeline.
// Throughput: one transaction per cycle, set by the fully pipelined divider
// (4 quotient bits per stage) and one multiply level per stage.
// The receiver cannot stall: the pipeline advances every cycle.
// Reset (synchronous) clears all valid bits and loads the register defaults:
// focal lengths 1.0, center 0, all distortion terms 0.
// Registers sit on an APB port at 8-byte spacing; write them only while no
// transaction is in flight.
module lens_distortion_point_mapper (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic signed [31:0]              req_point_x,
   input  logic signed [31:0]              req_point_y,
   output logic                            rsp_valid,
   output logic signed [31:0]              rsp_warped_x,
   output logic signed [31:0]              rsp_warped_y,
   output logic                            rsp_overflow,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [ldpm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [ldpm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ldpm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import ldpm_pkg::*;

   cfg_type            cfg;
   logic               take;
   logic               ux_vld, uy_vld;
   logic signed [31:0] u, v;
   logic               ux_ovf, uy_ovf;

   assign busy = 1'b0;
   assign take = start && !busy;

   ldpm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   ldpm_div u_div_x (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (take),
      .point   (req_point_x),
      .center  (cfg.prin_x),
      .focal   (cfg.focal_x),
      .out_vld (ux_vld),
      .quot    (u),
      .ovf     (ux_ovf)
   );

   ldpm_div u_div_y (
      .clock   (clock),
      .reset   (reset),
      .in_vld  (take),
      .point   (req_point_y),
      .center  (cfg.prin_y),
      .focal   (cfg.focal_y),
      .out_vld (uy_vld),
      .quot    (v),
      .ovf     (uy_ovf)
   );

   ldpm_core u_core (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .in_vld  (ux_vld && uy_vld),
      .u       (u),
      .v       (v),
      .in_ovf  (ux_ovf | uy_ovf),
      .out_vld (rsp_valid),
      .wx      (rsp_warped_x),
      .wy      (rsp_warped_y),
      .out_ovf (rsp_overflow)
   );

   a_lat_fwd: assert property (@(posedge clock) disable iff (reset)
      take |-> ##LATENCY rsp_valid)
      else $error("transaction dropped");

   a_lat_rev: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(take, LATENCY))
      else $error("spurious result");

   a_div_pair: assert property (@(posedge clock) disable iff (reset)
      ux_vld == uy_vld)
      else $error("divider lanes out of step");

endmodule
